[src/sos_pkg.sv]
// ----------------------------------------------------------------------------
// sos_pkg - shared types and constants of the orbit stepper
// Item layout, sequencer states, end causes and fixed-point helpers.
// ----------------------------------------------------------------------------
package sos_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } sos_op_e;

  typedef enum logic [1:0] {
    CAUSE_RUNNING  = 2'd0,
    CAUSE_ESCAPED  = 2'd1,
    CAUSE_CAPTURED = 2'd2
  } sos_cause_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_UQ,
    ST_S_TQ,
    ST_S_MQ,
    ST_THR,
    ST_THR_R,
    ST_HALVE,
    ST_HALVE_C,
    ST_P1,
    ST_P1R,
    ST_P2,
    ST_P2R,
    ST_P3,
    ST_P3R,
    ST_P4,
    ST_P4R,
    ST_P5,
    ST_P5R,
    ST_EMIT
  } sos_state_e;

  typedef struct packed {
    sos_op_e            op;
    logic signed [31:0] start_angle;
    logic [31:0]        start_radius;
    logic signed [31:0] radius_rate;
    logic signed [31:0] angle_step;
  } sos_item_t;

  localparam logic [31:0] MASS_RESET = 32'd16777216;
  localparam logic [31:0] THRESH_Q28 = 32'd24159191;   // 0.09 in Q28
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic [63:0] CAPTURE_LIM = 64'h0008_0000_0000_0000; // 2^51
  localparam logic [63:0] ONE_Q44 = 64'h0000_1000_0000_0000;     // 2^44

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // product magnitude back to Q-format, clamped, signed, saturated
  function automatic logic signed [31:0] mulq_fin(input logic [63:0] p, input logic neg,
                                                  input int unsigned sh);
    logic [63:0] m;
    m = p >> sh;
    if (m > 64'h8000_0000) m = 64'h8000_0000;
    if (neg) mulq_fin = ~m[31:0] + 32'd1;
    else if (m[31]) mulq_fin = S32_MAX;
    else mulq_fin = m[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) sat32 = S32_MAX;
    else if (v < -36'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

[src/sos_front.sv]
// ----------------------------------------------------------------------------
// sos_front - input side of the orbit stepper
// Takes items, tags them by request type and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module sos_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic signed [31:0]    start_angle_i,
  input  logic [31:0]           start_radius_i,
  input  logic signed [31:0]    radius_rate_i,
  input  logic signed [31:0]    angle_step_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output sos_pkg::sos_item_t    q_item_o
);
  import sos_pkg::*;

  sos_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].op           <= req_type_i ? OP_STEP : OP_START;
      mem_q[wr_ptr_q].start_angle  <= start_angle_i;
      mem_q[wr_ptr_q].start_radius <= start_radius_i;
      mem_q[wr_ptr_q].radius_rate  <= radius_rate_i;
      mem_q[wr_ptr_q].angle_step   <= angle_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[src/sos_div.sv]
// ----------------------------------------------------------------------------
// sos_div - shared unsigned divider
// 64 by 32 bit restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sos_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [63:0] quot_o,
  output logic        done_o
);
  logic [31:0] rem_q, rem_d, dvs_q;
  logic [63:0] quot_q, quot_d;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    trial  = '0;
    for (int k = 0; k < 2; k++) begin
      trial  = {rem_d, quot_d[63]};
      quot_d = {quot_d[62:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial     = trial - {1'b0, dvs_q};
        quot_d[0] = 1'b1;
      end
      rem_d = trial[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

[src/sos_back.sv]
// ----------------------------------------------------------------------------
// sos_back - execution side of the orbit stepper
// Sequencer over one shared multiplier and the shared divider; holds the ray.
// ----------------------------------------------------------------------------
module sos_back #(
  parameter int MAX_HALVINGS = 49
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           mass_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  sos_pkg::sos_item_t    q_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           radius_o,
  output logic signed [31:0]    angle_o,
  output logic                  ended_o,
  output logic [1:0]            end_cause_o
);
  import sos_pkg::*;

  localparam int NW = $clog2(MAX_HALVINGS + 2);
  localparam logic [NW-1:0] NMAX = NW'(MAX_HALVINGS);

  sos_state_e state_q, state_d;

  // ray state
  logic signed [31:0] u_q, u_d, ur_q, ur_d, ang_q, ang_d, step_q, step_d;
  logic               fin_q, fin_d;
  sos_cause_e         cause_q, cause_d;
  // working registers
  logic [31:0]        r0_q, r0_d, mr_q, mr_d, dm_q, dm_d, m_q, m_d;
  logic               rpn_q, rpn_d, dn_q, dn_d, opp_q, opp_d, rdiv_q, rdiv_d;
  logic [NW-1:0]      n_q, n_d;
  logic [63:0]        thr_q, thr_d, p_q;
  logic signed [31:0] tmp_q, tmp_d;
  // output slot
  logic               ov_q, ov_d;
  logic [31:0]        orad_q, orad_d;
  logic signed [31:0] oang_q, oang_d;
  logic               oend_q, oend_d;
  logic [1:0]         ocause_q, ocause_d;

  logic [31:0] mul_a, mul_b;
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic signed [31:0] mres;

  sos_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .quot_o    (div_q),
    .done_o    (div_done)
  );

  always_ff @(posedge clk_i) p_q <= mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    u_d = u_q;  ur_d = ur_q;  ang_d = ang_q;  step_d = step_q;
    fin_d = fin_q;  cause_d = cause_q;
    r0_d = r0_q;  mr_d = mr_q;  dm_d = dm_q;  m_d = m_q;
    rpn_d = rpn_q;  dn_d = dn_q;  opp_d = opp_q;  rdiv_d = rdiv_q;
    n_d = n_q;  thr_d = thr_q;  tmp_d = tmp_q;
    ov_d = ov_q && !out_ready_i;
    orad_d = orad_q;  oang_d = oang_q;  oend_d = oend_q;  ocause_d = ocause_q;
    mul_a = '0;  mul_b = '0;
    div_start = 1'b0;  div_dvd = ONE_Q44;  div_dvs = r0_q;
    q_pop_o = 1'b0;
    mres = '0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == OP_START) begin
            ang_d = q_item_i.start_angle;
            r0_d  = q_item_i.start_radius;
            mr_d  = mag32(q_item_i.radius_rate);
            rpn_d = q_item_i.radius_rate[31];
            dn_d  = q_item_i.angle_step[31];
            dm_d  = mag32(q_item_i.angle_step);
            opp_d = (q_item_i.radius_rate[31] && q_item_i.angle_step > 0) ||
                    (q_item_i.radius_rate > 0 && q_item_i.angle_step[31]);
            n_d   = '0;
            if (q_item_i.start_radius == '0) begin
              u_d = S32_MAX;
              m_d = (q_item_i.radius_rate != '0) ? S32_MAX : '0;
              state_d = ST_THR;
            end else begin
              div_start = 1'b1;
              div_dvs   = q_item_i.start_radius;
              state_d   = ST_S_UQ;
            end
          end else if (!fin_q) begin
            oang_d = ang_q;
            rdiv_d = (u_q > 0);
            div_start = (u_q > 0);
            div_dvs   = u_q;
            state_d   = ST_P1;
          end
        end
      end
      ST_S_UQ: begin
        if (div_done) begin
          u_d = (div_q > 64'(S32_MAX)) ? S32_MAX : div_q[31:0];
          div_start = 1'b1;
          div_dvd   = {4'd0, mr_q, 28'd0};
          state_d   = ST_S_TQ;
        end
      end
      ST_S_TQ: begin
        if (div_done) begin
          if (div_q[63:48] != '0) begin
            m_d = S32_MAX;
            state_d = ST_THR;
          end else begin
            div_start = 1'b1;
            div_dvd   = {div_q[47:0], 16'd0};
            state_d   = ST_S_MQ;
          end
        end
      end
      ST_S_MQ: begin
        if (div_done) begin
          m_d = (div_q > 64'(S32_MAX)) ? S32_MAX : div_q[31:0];
          state_d = ST_THR;
        end
      end
      ST_THR: begin
        mul_a = r0_q;
        mul_b = THRESH_Q28;
        state_d = ST_THR_R;
      end
      ST_THR_R: begin
        thr_d = p_q;
        state_d = ST_HALVE;
      end
      ST_HALVE, ST_HALVE_C: begin
        if (state_q == ST_HALVE_C && p_q > thr_q) begin
          dm_d = dm_q >> 1;
          n_d  = n_q + NW'(1);
          state_d = ST_HALVE;
        end else if (state_q == ST_HALVE && n_q < NMAX && opp_q && dm_q != '0) begin
          mul_a = mr_q;
          mul_b = dm_q;
          state_d = ST_HALVE_C;
        end else begin
          // halving settled: commit the new ray
          step_d  = dn_q ? (~dm_q + 32'd1) : dm_q;
          ur_d    = rpn_q ? m_q : (~m_q + 32'd1);
          fin_d   = 1'b0;
          cause_d = CAUSE_RUNNING;
          state_d = ST_IDLE;
        end
      end
      ST_P1: begin
        mul_a = mass_i;
        mul_b = mag32(u_q);
        state_d = ST_P1R;
      end
      ST_P1R: begin
        tmp_d = mulq_fin(p_q, u_q[31], 24);             // M*u
        state_d = ST_P2;
      end
      ST_P2: begin
        mul_a = mag32(tmp_q);
        mul_b = mag32(u_q);
        state_d = ST_P2R;
      end
      ST_P2R: begin
        mres  = mulq_fin(p_q, tmp_q[31] ^ u_q[31], 28); // M*u^2
        tmp_d = sat32(36'(sat32(36'(mres) * 36'sd3)) - 36'(u_q));
        state_d = ST_P3;
      end
      ST_P3: begin
        mul_a = mag32(step_q);
        mul_b = mag32(tmp_q);
        state_d = ST_P3R;
      end
      ST_P3R: begin
        mres = mulq_fin(p_q, step_q[31] ^ tmp_q[31], 28);
        ur_d = sat32(36'(ur_q) + 36'(mres));
        state_d = ST_P4;
      end
      ST_P4: begin
        mul_a = mag32(step_q);
        mul_b = mag32(ur_q);
        state_d = ST_P4R;
      end
      ST_P4R: begin
        mres = mulq_fin(p_q, step_q[31] ^ ur_q[31], 28);
        u_d  = sat32(36'(u_q) + 36'(mres));
        if (u_d[31]) begin
          fin_d   = 1'b1;
          cause_d = CAUSE_ESCAPED;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_P5;
        end
      end
      ST_P5: begin
        mul_a = mass_i;
        mul_b = u_q;
        state_d = ST_P5R;
      end
      ST_P5R: begin
        if (p_q > CAPTURE_LIM) begin
          fin_d   = 1'b1;
          cause_d = CAUSE_CAPTURED;
        end else begin
          ang_d = ang_q + (step_q >>> 4);
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!rdiv_q || div_done) begin
          orad_d   = (!rdiv_q || div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
          oend_d   = fin_q;
          ocause_d = cause_q;
          ov_d     = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;  mr_q <= mr_d;  dm_q <= dm_d;  m_q <= m_d;
    rpn_q <= rpn_d;  dn_q <= dn_d;  opp_q <= opp_d;  rdiv_q <= rdiv_d;
    n_q <= n_d;  thr_q <= thr_d;  tmp_q <= tmp_d;
    orad_q <= orad_d;  oang_q <= oang_d;  oend_q <= oend_d;  ocause_q <= ocause_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      u_q     <= '0;
      ur_q    <= '0;
      ang_q   <= '0;
      step_q  <= '0;
      fin_q   <= 1'b1;
      cause_q <= CAUSE_RUNNING;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      u_q     <= u_d;
      ur_q    <= ur_d;
      ang_q   <= ang_d;
      step_q  <= step_d;
      fin_q   <= fin_d;
      cause_q <= cause_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign radius_o    = orad_q;
  assign angle_o     = oang_q;
  assign ended_o     = oend_q;
  assign end_cause_o = ocause_q;

endmodule

[src/schwarzschild_orbit_stepper.sv]
// ----------------------------------------------------------------------------
// schwarzschild_orbit_stepper - light ray tracer around a central mass
// Euler integration of u'' = -u + 3Mu^2 in inverse radius, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): req_type 0 starts a ray from start_angle,
//   start_radius, radius_rate and angle_step; req_type 1 advances one step.
//   A start gives no result. A step gives one result item (radius, angle,
//   ended, end_cause) while a ray is active, and none once it has ended.
//   Config (APB, pready tied high): mass at byte address 0, Q8.24.
//   Write it only while the block is idle.
// Flow:
//   A step forms 1/u on the shared radix-4 divider, and up to five chained
//   multiplies on the shared 32x32 multiplier overlap with it. A start
//   takes up to three divides plus a multiply and a compare per step
//   halving. Items queue two deep in front of the sequencer, so the input
//   takes up to two items while a result waits; a result is held in the output
//   register until taken, and the sequencer waits for that slot before
//   the next item.
// Reset:
//   Asynchronous, active low. Mass returns to 1.0, no ray is active.
// ----------------------------------------------------------------------------
module schwarzschild_orbit_stepper #(
  parameter int MAX_HALVINGS = 49
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic signed [31:0] start_angle_i,
  input  logic [31:0]        start_radius_i,
  input  logic signed [31:0] radius_rate_i,
  input  logic signed [31:0] angle_step_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        radius_o,
  output logic signed [31:0] angle_o,
  output logic               ended_o,
  output logic [1:0]         end_cause_o
);
  import sos_pkg::*;

  logic [31:0] mass_q;
  logic        q_valid, q_pop;
  sos_item_t   q_item;

  // register file: one register, index from paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? mass_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= MASS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mass_q <= pwdata;
    end
  end

  sos_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .start_angle_i (start_angle_i),
    .start_radius_i(start_radius_i),
    .radius_rate_i (radius_rate_i),
    .angle_step_i  (angle_step_i),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_item_o      (q_item)
  );

  sos_back #(
    .MAX_HALVINGS(MAX_HALVINGS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mass_i     (mass_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .radius_o   (radius_o),
    .angle_o    (angle_o),
    .ended_o    (ended_o),
    .end_cause_o(end_cause_o)
  );

endmodule

[src/sos_checker.sv]
// ----------------------------------------------------------------------------
// sos_checker - port-level checks of the orbit stepper
// Result handshake and end flag consistency, bound to the top level.
// ----------------------------------------------------------------------------
module sos_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [31:0]        radius_o,
  input logic signed [31:0] angle_o,
  input logic               ended_o,
  input logic [1:0]         end_cause_o
);
  import sos_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(radius_o) && $stable(angle_o))
    else $error("result changed while stalled");

  // ended is set exactly when a cause is reported
  a_end_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ended_o == (end_cause_o != CAUSE_RUNNING)))
    else $error("ended and end cause disagree");

  // no undefined cause code
  a_cause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (end_cause_o == CAUSE_RUNNING || end_cause_o == CAUSE_ESCAPED ||
                     end_cause_o == CAUSE_CAPTURED))
    else $error("bad end cause");

endmodule

bind schwarzschild_orbit_stepper sos_checker u_sos_checker (.*);

[bench/schwarzschild_orbit_stepper_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schwarzschild_orbit_stepper_tb - self-checking bench for the orbit stepper
// Drives start and step items with random gaps and output stalls, predicts
// each sample from an internal fixed-point copy of the ray state and checks
// every result field in order. Mass is rewritten between phases.
// ----------------------------------------------------------------------------
module schwarzschild_orbit_stepper_tb;
  import sos_pkg::*;

  localparam int PERIOD = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // config port
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // item ports
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic signed [31:0] start_angle_i = '0;
  logic [31:0] start_radius_i = '0;
  logic signed [31:0] radius_rate_i = '0;
  logic signed [31:0] angle_step_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] radius_o;
  logic signed [31:0] angle_o;
  logic ended_o;
  logic [1:0] end_cause_o;

  schwarzschild_orbit_stepper DUT (.*);

  always begin
    #(PERIOD / 2) clk_i = 1'b1;
    #(PERIOD / 2) clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] angle;
    logic        ended;
    logic [1:0]  cause;
  } sample_t;

  // ray state mirrored in the bench
  logic [31:0]  mass_q24;
  longint       u_q28, du_q28, phi_q24, step_q28;
  bit           ray_done;
  logic [1:0]   ray_cause;
  sample_t      pending_samples[$];

  int  mismatches = 0;
  bit  quiet_mode = 1'b0;  // no idling on either side

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fix_mul(longint a, longint b, int sh);
    longint unsigned ma, mb, p;
    bit neg;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    p = (ma * mb) >> sh;
    if (p > 64'h8000_0000) p = 64'h8000_0000;
    return clamp32(neg ? -longint'(p) : longint'(p));
  endfunction

  function automatic void launch_ray(logic signed [31:0] a0, logic [31:0] r0,
                                     logic signed [31:0] rp, logic signed [31:0] d);
    longint unsigned mr, dm, m, q, t;
    bit opposite;
    int n;
    mr = rp < 0 ? -longint'(rp) : longint'(rp);
    dm = d < 0 ? -longint'(d) : longint'(d);
    opposite = (rp < 0 && d > 0) || (rp > 0 && d < 0);
    n = 0;
    phi_q24 = a0;
    if (r0 == 0) begin
      u_q28 = 64'sd2147483647;
      m = mr != 0 ? 64'd2147483647 : 0;
    end else begin
      q = (64'd1 << 44) / r0;
      t = (mr << 28) / r0;
      u_q28 = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
      m = t >= (64'd1 << 48) ? 64'd2147483647 : (t << 16) / r0;
      if (m > 64'd2147483647) m = 64'd2147483647;
    end
    du_q28 = rp < 0 ? longint'(m) : -longint'(m);
    while (n < 49 && opposite && dm != 0 && mr * dm > r0 * 64'd24159191) begin
      dm >>= 1;
      n++;
    end
    step_q28 = d < 0 ? -longint'(dm) : longint'(dm);
    ray_done = 1'b0;
    ray_cause = CAUSE_RUNNING;
  endfunction

  // one Euler step; returns 1 and the sample when a ray is active
  function automatic bit advance_ray(output sample_t s);
    longint u, mu, mu2, acc, add;
    longint unsigned rad;
    if (ray_done) return 0;
    u = u_q28;
    if (u <= 0) rad = 64'hFFFF_FFFF;
    else begin
      rad = (64'd1 << 44) / longint'(u);
      if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
    end
    s.radius = rad[31:0];
    s.angle = phi_q24[31:0];
    mu = fix_mul(longint'({32'd0, mass_q24}), u, 24);
    mu2 = fix_mul(mu, u, 28);
    acc = clamp32(clamp32(3 * mu2) - u);
    du_q28 = clamp32(du_q28 + fix_mul(step_q28, acc, 28));
    u_q28 = clamp32(u + fix_mul(step_q28, du_q28, 28));
    if (u_q28 < 0) begin
      ray_done = 1'b1;
      ray_cause = CAUSE_ESCAPED;
    end else if (longint'({32'd0, mass_q24}) * u_q28 > (64'sd1 <<< 51)) begin
      ray_done = 1'b1;
      ray_cause = CAUSE_CAPTURED;
    end else begin
      if (step_q28 >= 0) add = step_q28 >>> 4;
      else add = -longint'((longint'(-step_q28) + 15) >> 4);
      phi_q24 = longint'($signed(32'(phi_q24 + add)));
    end
    s.ended = ray_done;
    s.cause = ray_cause;
    return 1;
  endfunction

  // append a predicted sample to the scoreboard
  function automatic void queue_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic idle_gap();
    if (!quiet_mode && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // send one item and update the prediction when it is accepted; valid is
  // dropped by the next gap or by drain
  task automatic send_item(sos_op_e op, logic signed [31:0] a0, logic [31:0] r0,
                           logic signed [31:0] rp, logic signed [31:0] d);
    sample_t s;
    idle_gap();
    in_valid_i <= 1'b1;
    req_type_i <= op;
    start_angle_i <= a0;
    start_radius_i <= r0;
    radius_rate_i <= rp;
    angle_step_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_START) launch_ray(a0, r0, rp, d);
    else if (advance_ray(s)) queue_sample(s);
    @(negedge clk_i);
  endtask

  task automatic start_ray_item(logic [31:0] r0, logic signed [31:0] rp,
                                logic signed [31:0] d);
    send_item(OP_START, $urandom, r0, rp, d);
  endtask

  task automatic step_item();
    send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);  // a start with full halving may still be busy
  endtask

  task automatic write_mass(logic [31:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mass_q24 = val;
  endtask

  // ---------------------------------------------------------------- checking
  always @(negedge clk_i)
    out_ready_i <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 12);

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        want = pending_samples.pop_front();
        if (radius_o !== want.radius || angle_o !== want.angle ||
            ended_o !== want.ended || end_cause_o !== want.cause) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: radius %h/%h angle %h/%h ended %b/%b cause %0d/%0d",
                     $realtime, want.radius, radius_o, want.angle, angle_o,
                     want.ended, ended_o, want.cause, end_cause_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Steps with no active ray, right after reset: must be ignored.
  task automatic test_idle_steps();
    step_item();
    step_item();
  endtask

  // Field extremes, zero radius, halving and both end causes.
  task automatic test_directed();
    start_ray_item(32'h000A_0000, 32'sd0, 32'sh0100_0000);  // r=10 circle-ish
    repeat (3) step_item();
    start_ray_item(32'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);  // zero radius
    repeat (2) step_item();
    start_ray_item(32'd0, 32'sd0, 32'sd0);
    step_item();
    start_ray_item(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);  // extreme fields, halving
    repeat (2) step_item();
    start_ray_item(32'h0001_0000, 32'sd0, 32'sh0100_0000);  // r=1: captured
    repeat (2) step_item();
    start_ray_item(32'h0064_0000, 32'sh0100_0000, 32'sh1000_0000);  // escapes
    repeat (3) step_item();
    step_item();  // after the end: ignored
  endtask

  // Rays with plausible geometry and random content, plus noise.
  task automatic test_random_rays(int count);
    int k, len;
    logic [31:0] r0;
    k = 0;
    while (k < count) begin
      case ($urandom_range(9))
        0: r0 = $urandom;
        1: r0 = $urandom_range(0, 3);
        default: r0 = $urandom_range(32'h0001_0000, 32'h0100_0000);
      endcase
      if ($urandom_range(9) == 0)
        start_ray_item(r0, $urandom, $urandom);
      else
        start_ray_item(r0, $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
                       $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      k++;
      len = $urandom_range(1, 25);
      repeat (len) begin
        step_item();
        k++;
      end
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    mass_q24 = MASS_RESET;
    u_q28 = 0; du_q28 = 0; phi_q24 = 0; step_q28 = 0;
    ray_done = 1'b1; ray_cause = CAUSE_RUNNING;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_steps();
    test_directed();
    write_mass(32'd0);
    test_directed();
    write_mass(32'hFFFF_FFFF);
    test_directed();
    write_mass(32'h0080_0000);
    test_random_rays(400);
    drain();  // sender holds off until all results are back
    quiet_mode = 1'b1;
    test_random_rays(200);
    quiet_mode = 1'b0;
    write_mass($urandom);
    test_random_rays(300);
    write_mass(MASS_RESET);
    test_random_rays(300);

    drain();
    if (mismatches == 0) $display("schwarzschild_orbit_stepper test passed");
    else $display("schwarzschild_orbit_stepper test failed");
    $finish;
  end

  initial begin
    #(PERIOD * 2000000);
    $display("schwarzschild_orbit_stepper test failed");
    $finish;
  end

endmodule

[files.f]
src/sos_pkg.sv
src/sos_front.sv
src/sos_div.sv
src/sos_back.sv
src/schwarzschild_orbit_stepper.sv
src/sos_checker.sv
bench/schwarzschild_orbit_stepper_tb.sv
